// ===== src/qte_pkg.sv =====
// qte_pkg: widths, constants and the arctangent table for the quaternion to Euler unit.
// No dependencies.
`timescale 1ns / 1ps
package qte_pkg;
   localparam int QW           = 15;   // Q1.14 input component
   localparam int PW           = 30;   // product of two components
   localparam int TW           = 32;   // sine and cosine terms, Q28
   localparam int SQ_BITS      = 29;   // root bits, up to 2^28
   localparam int RW           = 58;   // radicand / remainder
   localparam int CW           = 36;   // CORDIC x and y
   localparam int AW           = 26;   // CORDIC angle, 2^-16 degree
   localparam int ANGLE_ITERATIONS = 16;
   localparam int LANES        = 3;
   localparam int LATENCY      = 6 + SQ_BITS + ANGLE_ITERATIONS;
   localparam int HALF_TURN    = 11520;
   localparam int QUARTER_TURN = 5760;
   localparam logic signed [AW-1:0] DEG90_FINE = AW'(90 * 65536);
   localparam logic signed [TW-1:0] ONE_Q28    = TW'(1 << 28);

   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   function automatic logic [23:0] atan_tab(input int n);
      logic [23:0] v;
      case (n)
         0: v = 24'd2949120;   1: v = 24'd1740967;   2: v = 24'd919879;
         3: v = 24'd466945;    4: v = 24'd234379;    5: v = 24'd117304;
         6: v = 24'd58666;     7: v = 24'd29335;     8: v = 24'd14668;
         9: v = 24'd7334;     10: v = 24'd3667;     11: v = 24'd1833;
         12: v = 24'd917;     13: v = 24'd458;      14: v = 24'd229;
         15: v = 24'd115;     16: v = 24'd57;       17: v = 24'd29;
         18: v = 24'd14;      19: v = 24'd7;        20: v = 24'd4;
         21: v = 24'd2;       22: v = 24'd1;
         default: v = 24'd0;
      endcase
      return v;
   endfunction
endpackage

// ===== src/quaternion_to_euler_angles_unit.sv =====
// Quaternion to Euler (Z-Y-X) angles: products, pipelined square root, three CORDIC lanes.
// Depends on qte_pkg.
// Throughput: one item per cycle; busy stays low, every stage advances each cycle.
// The bit-serial square root (29 stages) and the CORDIC iterations set the depth.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [qte_pkg::QW-1:0]     req_quat_real,
   input  logic signed [qte_pkg::QW-1:0]     req_quat_i,
   input  logic signed [qte_pkg::QW-1:0]     req_quat_j,
   input  logic signed [qte_pkg::QW-1:0]     req_quat_k,
   output logic                              rsp_valid,
   output logic signed [14:0]                rsp_roll_angle,
   output logic signed [13:0]                rsp_pitch_angle,
   output logic signed [14:0]                rsp_yaw_angle,
   output logic                              rsp_pitch_clamped
);
   import qte_pkg::*;

   typedef logic signed [CW-1:0] cord_type;
   typedef logic signed [AW-1:0] ang_type;
   typedef logic signed [TW-1:0] term_type;

   assign busy = 1'b0;

   // stage A: input capture
   logic                 a_vld_ff;
   logic signed [QW-1:0] a_w_ff, a_i_ff, a_j_ff, a_k_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= start & ~busy;
      a_w_ff <= req_quat_real;
      a_i_ff <= req_quat_i;
      a_j_ff <= req_quat_j;
      a_k_ff <= req_quat_k;
   end

   // stage B: products
   logic                 b_vld_ff;
   logic signed [PW-1:0] b_wi_ff, b_jk_ff, b_ii_ff, b_jj_ff, b_wj_ff,
                         b_ki_ff, b_wk_ff, b_ij_ff, b_kk_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
      b_wi_ff <= a_w_ff * a_i_ff;
      b_jk_ff <= a_j_ff * a_k_ff;
      b_ii_ff <= a_i_ff * a_i_ff;
      b_jj_ff <= a_j_ff * a_j_ff;
      b_wj_ff <= a_w_ff * a_j_ff;
      b_ki_ff <= a_k_ff * a_i_ff;
      b_wk_ff <= a_w_ff * a_k_ff;
      b_ij_ff <= a_i_ff * a_j_ff;
      b_kk_ff <= a_k_ff * a_k_ff;
   end

   // stage C: sine and cosine terms
   logic     c_vld_ff, c_clamp_ff;
   term_type c_rs_ff, c_rc_ff, c_ps_ff, c_ys_ff, c_yc_ff;
   term_type c_ps_in;
   assign c_ps_in = (TW'(b_wj_ff) - TW'(b_ki_ff)) <<< 1;
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else       c_vld_ff <= b_vld_ff;
      c_rs_ff    <= (TW'(b_wi_ff) + TW'(b_jk_ff)) <<< 1;
      c_rc_ff    <= ONE_Q28 - ((TW'(b_ii_ff) + TW'(b_jj_ff)) <<< 1);
      c_ps_ff    <= c_ps_in;
      c_ys_ff    <= (TW'(b_wk_ff) + TW'(b_ij_ff)) <<< 1;
      c_yc_ff    <= ONE_Q28 - ((TW'(b_jj_ff) + TW'(b_kk_ff)) <<< 1);
      c_clamp_ff <= (c_ps_in >= ONE_Q28) || (c_ps_in <= -ONE_Q28);
   end

   // stage D: radicand 2^56 - ps^2 (only used when not clamped)
   logic signed [SQ_BITS-1:0] d_ps29;
   logic [RW-1:0]             d_sq;
   assign d_ps29 = c_ps_ff[SQ_BITS-1:0];
   assign d_sq   = $unsigned(RW'(d_ps29) * RW'(d_ps29));

   logic                 sq_vld_ff   [0:SQ_BITS];
   logic                 sq_clamp_ff [0:SQ_BITS];
   term_type             sq_rs_ff    [0:SQ_BITS];
   term_type             sq_rc_ff    [0:SQ_BITS];
   term_type             sq_ps_ff    [0:SQ_BITS];
   term_type             sq_ys_ff    [0:SQ_BITS];
   term_type             sq_yc_ff    [0:SQ_BITS];
   logic [RW-1:0]        sq_rem_ff   [0:SQ_BITS];
   logic [SQ_BITS-1:0]   sq_root_ff  [0:SQ_BITS];

   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff[0] <= 1'b0;
      else       sq_vld_ff[0] <= c_vld_ff;
      sq_clamp_ff[0] <= c_clamp_ff;
      sq_rs_ff[0]    <= c_rs_ff;
      sq_rc_ff[0]    <= c_rc_ff;
      sq_ps_ff[0]    <= c_ps_ff;
      sq_ys_ff[0]    <= c_ys_ff;
      sq_yc_ff[0]    <= c_yc_ff;
      sq_rem_ff[0]   <= (RW'(1) << 56) - d_sq;
      sq_root_ff[0]  <= '0;
   end

   // restoring square root, one result bit per stage
   for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
      localparam int B = SQ_BITS - 1 - k;
      logic [RW-1:0] trial;
      logic          take;
      assign trial = (RW'(sq_root_ff[k]) << (B + 1)) + (RW'(1) << (2 * B));
      assign take  = sq_rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         if (reset) sq_vld_ff[k+1] <= 1'b0;
         else       sq_vld_ff[k+1] <= sq_vld_ff[k];
         sq_clamp_ff[k+1] <= sq_clamp_ff[k];
         sq_rs_ff[k+1]    <= sq_rs_ff[k];
         sq_rc_ff[k+1]    <= sq_rc_ff[k];
         sq_ps_ff[k+1]    <= sq_ps_ff[k];
         sq_ys_ff[k+1]    <= sq_ys_ff[k];
         sq_yc_ff[k+1]    <= sq_yc_ff[k];
         sq_rem_ff[k+1]   <= take ? sq_rem_ff[k] - trial : sq_rem_ff[k];
         sq_root_ff[k+1]  <= take ? (sq_root_ff[k] | (SQ_BITS'(1) << B)) : sq_root_ff[k];
      end
   end

   // CORDIC lanes: pre-rotation stage then one stage per iteration
   logic     cr_vld_ff   [0:ANGLE_ITERATIONS];
   logic     cr_clamp_ff [0:ANGLE_ITERATIONS];
   logic     cr_neg_ff   [0:ANGLE_ITERATIONS];
   logic     cr_zero_ff  [0:ANGLE_ITERATIONS][LANES];
   cord_type cr_x_ff     [0:ANGLE_ITERATIONS][LANES];
   cord_type cr_y_ff     [0:ANGLE_ITERATIONS][LANES];
   ang_type  cr_a_ff     [0:ANGLE_ITERATIONS][LANES];

   cord_type pre_x [LANES];
   cord_type pre_y [LANES];
   assign pre_y[LANE_ROLL]  = CW'(sq_rs_ff[SQ_BITS]);
   assign pre_x[LANE_ROLL]  = CW'(sq_rc_ff[SQ_BITS]);
   assign pre_y[LANE_PITCH] = CW'(sq_ps_ff[SQ_BITS]);
   assign pre_x[LANE_PITCH] = CW'({1'b0, sq_root_ff[SQ_BITS]});
   assign pre_y[LANE_YAW]   = CW'(sq_ys_ff[SQ_BITS]);
   assign pre_x[LANE_YAW]   = CW'(sq_yc_ff[SQ_BITS]);

   always_ff @(posedge clock) begin
      if (reset) cr_vld_ff[0] <= 1'b0;
      else       cr_vld_ff[0] <= sq_vld_ff[SQ_BITS];
      cr_clamp_ff[0] <= sq_clamp_ff[SQ_BITS];
      cr_neg_ff[0]   <= sq_ps_ff[SQ_BITS][TW-1];
      for (int l = 0; l < LANES; l++) begin
         cr_zero_ff[0][l] <= (pre_x[l] == '0) && (pre_y[l] == '0);
         if (pre_x[l] < 0) begin
            if (pre_y[l] >= 0) begin
               cr_x_ff[0][l] <= pre_y[l];
               cr_y_ff[0][l] <= -pre_x[l];
               cr_a_ff[0][l] <= DEG90_FINE;
            end else begin
               cr_x_ff[0][l] <= -pre_y[l];
               cr_y_ff[0][l] <= pre_x[l];
               cr_a_ff[0][l] <= -DEG90_FINE;
            end
         end else begin
            cr_x_ff[0][l] <= pre_x[l];
            cr_y_ff[0][l] <= pre_y[l];
            cr_a_ff[0][l] <= '0;
         end
      end
   end

   for (genvar n = 0; n < ANGLE_ITERATIONS; n++) begin : g_iter
      localparam ang_type STEP = AW'(atan_tab(n));
      always_ff @(posedge clock) begin
         if (reset) cr_vld_ff[n+1] <= 1'b0;
         else       cr_vld_ff[n+1] <= cr_vld_ff[n];
         cr_clamp_ff[n+1] <= cr_clamp_ff[n];
         cr_neg_ff[n+1]   <= cr_neg_ff[n];
         for (int l = 0; l < LANES; l++) begin
            cr_zero_ff[n+1][l] <= cr_zero_ff[n][l];
            if (cr_y_ff[n][l] > 0) begin
               cr_x_ff[n+1][l] <= cr_x_ff[n][l] + (cr_y_ff[n][l] >>> n);
               cr_y_ff[n+1][l] <= cr_y_ff[n][l] - (cr_x_ff[n][l] >>> n);
               cr_a_ff[n+1][l] <= cr_a_ff[n][l] + STEP;
            end else begin
               cr_x_ff[n+1][l] <= cr_x_ff[n][l] - (cr_y_ff[n][l] >>> n);
               cr_y_ff[n+1][l] <= cr_y_ff[n][l] + (cr_x_ff[n][l] >>> n);
               cr_a_ff[n+1][l] <= cr_a_ff[n][l] - STEP;
            end
         end
      end
   end

   // output stage: round to 1/64 degree, clamp, pitch saturation
   logic signed [AW-11:0] rnd [LANES];
   logic signed [15:0]    ang [LANES];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rnd[l] = (AW-10)'((cr_a_ff[ANGLE_ITERATIONS][l] + ang_type'(512)) >>> 10);
         if (cr_zero_ff[ANGLE_ITERATIONS][l])        ang[l] = '0;
         else if (rnd[l] > HALF_TURN)                ang[l] = 16'(HALF_TURN);
         else if (rnd[l] < -HALF_TURN)               ang[l] = -16'(HALF_TURN);
         else                                        ang[l] = 16'(rnd[l]);
      end
   end

   logic signed [15:0] pitch_in;
   always_comb begin
      if (cr_clamp_ff[ANGLE_ITERATIONS])
         pitch_in = cr_neg_ff[ANGLE_ITERATIONS] ? -16'(QUARTER_TURN) : 16'(QUARTER_TURN);
      else if (ang[LANE_PITCH] > QUARTER_TURN)  pitch_in = 16'(QUARTER_TURN);
      else if (ang[LANE_PITCH] < -QUARTER_TURN) pitch_in = -16'(QUARTER_TURN);
      else                                      pitch_in = ang[LANE_PITCH];
   end

   logic               rsp_valid_ff, rsp_clamp_ff;
   logic signed [14:0] rsp_roll_ff, rsp_yaw_ff;
   logic signed [13:0] rsp_pitch_ff;
   logic signed [15:0] roll_neg;
   assign roll_neg = -ang[LANE_ROLL];
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cr_vld_ff[ANGLE_ITERATIONS];
      rsp_roll_ff  <= roll_neg[14:0];
      rsp_pitch_ff <= pitch_in[13:0];
      rsp_yaw_ff   <= ang[LANE_YAW][14:0];
      rsp_clamp_ff <= cr_clamp_ff[ANGLE_ITERATIONS];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = rsp_roll_ff;
   assign rsp_pitch_angle   = rsp_pitch_ff;
   assign rsp_yaw_angle     = rsp_yaw_ff;
   assign rsp_pitch_clamped = rsp_clamp_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item lost in pipeline");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without item");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 14'sd5760 && rsp_pitch_angle >= -14'sd5760))
      else $error("pitch out of range");
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pitch_clamped) |->
         (rsp_pitch_angle == 14'sd5760 || rsp_pitch_angle == -14'sd5760))
      else $error("clamped pitch not at 90 degrees");
`endif
endmodule
